// ===== hdl/keyed_value_lexer_assert.svh =====
// Assertion macros shared by the lexer modules; clocked on clk, quiet during reset.
`ifndef KEYED_VALUE_LEXER_ASSERT_SVH
`define KEYED_VALUE_LEXER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle check: the property holds at every edge out of reset.
`define KVL_ASSERT(label, prop, msg) label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Next-cycle check: when ante holds, cons holds at the following edge.
`define KVL_ASSERT_NEXT(label, ante, cons, msg) label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define KVL_ASSERT(label, prop, msg)
`define KVL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/kvl_pkg.sv =====
// Types and constants shared by the keyed-value lexer modules.
`default_nettype none
package kvl_pkg;

	// Lexer modes.
	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_PCT     = 3'd1,
		MODE_ID      = 3'd2,
		MODE_TOOLONG = 3'd3,
		MODE_NUM     = 3'd4,
		MODE_COMMENT = 3'd5
	} lex_mode_t;

	// Token kinds carried by a closing result.
	typedef enum logic [2:0] {
		KIND_ID   = 3'd0,
		KIND_EQ   = 3'd1,
		KIND_INT  = 3'd2,
		KIND_DBL  = 3'd3,
		KIND_EOF  = 3'd4,
		KIND_LONG = 3'd5
	} token_kind_t;

	// Character codes.
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// Integer magnitude limits.
	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// One result item.
	typedef struct packed {
		logic        text_valid;
		logic [7:0]  text_byte;
		logic        token_done;
		token_kind_t token_kind;
		logic [31:0] int_value;
	} result_t;

	// All results caused by one input item.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	// Queue status seen by front and back.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage
`default_nettype wire

// ===== hdl/kvl_front.sv =====
// Front end: accepts characters, runs the lexer state and queues the results.
`default_nettype none
module kvl_front #(
	parameter int ID_LEN_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   end_of_input,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [ID_LEN_BITS-1:0] cfg_data,
	input  wire kvl_pkg::q_status_t     q_status,
	output logic                        push,
	output kvl_pkg::entry_t             push_data
);
	import kvl_pkg::*;

	localparam logic [ID_LEN_BITS-1:0] IdLenReset = ID_LEN_BITS'(1023);

	lex_mode_t               mode_q, mode_d;
	logic                    all_int_q, all_int_d;
	logic [31:0]             accum_q, accum_d;
	logic                    neg_q, neg_d;
	logic                    ended_q, ended_d;
	logic [ID_LEN_BITS-1:0]  id_len_q, id_len_d;
	logic [ID_LEN_BITS-1:0]  max_id_q;

	logic        accept;
	logic        is_sep, is_eq, is_digit, pending;
	logic        base_all, base_ended, nb_all, nb_ended;
	logic [31:0] base_accum, nb_accum;
	logic [35:0] mul10;
	result_t     close_r, text_r, eq_r, eof_r;
	logic        has0, has1;
	result_t     r0, r1;

	// Handshake: the queue alone holds off the source.
	assign in_stall  = q_status.full;
	assign accept    = in_valid && !q_status.full;
	assign cfg_ready = 1'b1;

	// Character classes.
	assign is_sep   = (in_byte <= CH_SPACE) || (in_byte == CH_COMMA);
	assign is_eq    = (in_byte == CH_EQUALS);
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign pending  = (mode_q inside {MODE_PCT, MODE_ID, MODE_TOOLONG, MODE_NUM});

	// Number state seen by this byte; a new number starts from cleared state.
	assign base_all   = (mode_q == MODE_BETWEEN) ? 1'b1 : all_int_q;
	assign base_ended = (mode_q == MODE_BETWEEN) ? 1'b0 : ended_q;
	assign base_accum = (mode_q == MODE_BETWEEN) ? 32'd0 : accum_q;

	// Decimal accumulate with saturation at the magnitude limit.
	assign mul10 = ({4'd0, base_accum} << 3) + ({4'd0, base_accum} << 1)
		+ {32'd0, in_byte[3:0]};

	always_comb begin
		nb_all = base_all && (is_digit || (in_byte == CH_MINUS));
		if (is_digit && !base_ended) begin
			nb_accum = (mul10 > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mul10[31:0];
			nb_ended = base_ended;
		end else begin
			nb_accum = base_accum;
			nb_ended = 1'b1;
		end
	end

	// Fixed result shapes.
	always_comb begin
		text_r            = '0;
		text_r.text_valid = 1'b1;
		text_r.text_byte  = in_byte;
		eq_r              = '0;
		eq_r.token_done   = 1'b1;
		eq_r.token_kind   = KIND_EQ;
		eof_r             = '0;
		eof_r.token_done  = 1'b1;
		eof_r.token_kind  = KIND_EOF;
	end

	// Closing result of the token in progress.
	always_comb begin
		close_r            = '0;
		close_r.token_done = 1'b1;
		close_r.token_kind = KIND_ID;
		if (mode_q == MODE_TOOLONG) begin
			close_r.token_kind = KIND_LONG;
		end else if (mode_q == MODE_NUM) begin
			if (all_int_q) begin
				close_r.token_kind = KIND_INT;
				if (neg_q) begin
					close_r.int_value = 32'd0 - accum_q;
				end else begin
					close_r.int_value = accum_q[31] ? POS_LIMIT : accum_q;
				end
			end else begin
				close_r.token_kind = KIND_DBL;
			end
		end
	end

	// Next state and results for one character or end mark.
	always_comb begin
		mode_d   = mode_q;
		all_int_d = all_int_q;
		accum_d  = accum_q;
		neg_d    = neg_q;
		ended_d  = ended_q;
		id_len_d = id_len_q;
		has0     = 1'b0;
		has1     = 1'b0;
		r0       = '0;
		r1       = '0;
		if (end_of_input) begin
			has0   = 1'b1;
			mode_d = MODE_BETWEEN;
			if (pending) begin
				has1 = 1'b1;
				r0   = close_r;
				r1   = eof_r;
			end else begin
				r0 = eof_r;
			end
		end else begin
			unique case (mode_q) inside
				MODE_BETWEEN: begin
					if (is_sep) begin
						mode_d = MODE_BETWEEN;
					end else if (is_eq) begin
						has0 = 1'b1;
						r0   = eq_r;
					end else if (in_byte == CH_HASH) begin
						mode_d = MODE_COMMENT;
					end else if (in_byte == CH_PERCENT) begin
						mode_d   = MODE_PCT;
						id_len_d = '0;
					end else begin
						mode_d = MODE_NUM;
						has0   = 1'b1;
						r0     = text_r;
						if (in_byte == CH_MINUS) begin
							neg_d     = 1'b1;
							all_int_d = 1'b1;
							accum_d   = 32'd0;
							ended_d   = 1'b0;
						end else begin
							neg_d     = 1'b0;
							all_int_d = nb_all;
							accum_d   = nb_accum;
							ended_d   = nb_ended;
						end
					end
				end
				MODE_COMMENT: begin
					if (in_byte == CH_NEWLINE) begin
						mode_d = MODE_BETWEEN;
					end
				end
				MODE_PCT, MODE_ID, MODE_TOOLONG: begin
					if ((mode_q == MODE_PCT) && (in_byte == CH_PERCENT)) begin
						mode_d = MODE_COMMENT;
					end else if (is_sep || is_eq) begin
						mode_d = MODE_BETWEEN;
						has0   = 1'b1;
						r0     = close_r;
						has1   = is_eq;
						r1     = eq_r;
					end else if (mode_q != MODE_TOOLONG) begin
						if (id_len_q >= max_id_q) begin
							mode_d = MODE_TOOLONG;
						end else begin
							id_len_d = id_len_q + 1'b1;
							mode_d   = MODE_ID;
							has0     = 1'b1;
							r0       = text_r;
						end
					end
				end
				MODE_NUM: begin
					if (is_sep || is_eq) begin
						mode_d = MODE_BETWEEN;
						has0   = 1'b1;
						r0     = close_r;
						has1   = is_eq;
						r1     = eq_r;
					end else begin
						all_int_d = nb_all;
						accum_d   = nb_accum;
						ended_d   = nb_ended;
						has0      = 1'b1;
						r0        = text_r;
					end
				end
				default: begin
					mode_d = MODE_BETWEEN;
				end
			endcase
		end
	end

	// Queue write: items without results are dropped here.
	assign push          = accept && has0;
	assign push_data.two = has1;
	assign push_data.r0  = r0;
	assign push_data.r1  = has1 ? r1 : '0;

	// Lexer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_BETWEEN;
			all_int_q <= 1'b1;
			accum_q   <= 32'd0;
			neg_q     <= 1'b0;
			ended_q   <= 1'b0;
			id_len_q  <= '0;
		end else if (accept) begin
			mode_q    <= mode_d;
			all_int_q <= all_int_d;
			accum_q   <= accum_d;
			neg_q     <= neg_d;
			ended_q   <= ended_d;
			id_len_q  <= id_len_d;
		end
	end

	// Identifier length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_id_q <= IdLenReset;
		end else if (cfg_valid && cfg_ready) begin
			max_id_q <= cfg_data;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/kvl_queue.sv =====
// Short queue of per-character result entries between front and back.
`default_nettype none
`include "keyed_value_lexer_assert.svh"
module kvl_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire kvl_pkg::entry_t    push_data,
	input  wire logic               pop,
	output kvl_pkg::entry_t         head,
	output kvl_pkg::q_status_t      status
);
	import kvl_pkg::*;

	entry_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The front must never write a full queue, and the back never read an empty one.
	`KVL_ASSERT(a_no_overflow, push |-> !status.full, "queue written while full")
	`KVL_ASSERT(a_no_underflow, pop |-> !status.empty, "queue read while empty")

endmodule
`default_nettype wire

// ===== hdl/kvl_back.sv =====
// Back end: drains queue entries into the registered result channel.
`default_nettype none
`include "keyed_value_lexer_assert.svh"
module kvl_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kvl_pkg::entry_t    head,
	input  wire kvl_pkg::q_status_t q_status,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output kvl_pkg::result_t        out_res,
	output logic                    out_last
);
	import kvl_pkg::*;

	logic    out_valid_q;
	result_t out_res_q;
	logic    out_last_q;
	logic    sub_q;
	logic    can_load, load, head_last;

	// The output register takes a new result when empty or when its result leaves.
	assign can_load  = !out_valid_q || !out_stall;
	assign load      = can_load && !q_status.empty;
	assign head_last = sub_q || !head.two;
	assign pop       = load && head_last;

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_last  = out_last_q;

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q  <= sub_q ? head.r1 : head.r0;
			out_last_q <= head_last;
		end
	end

	// Output valid and position within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= !q_status.empty;
			if (load) begin
				sub_q <= !head_last;
			end
		end
	end

	// A half-sent entry stays at the head, and a result is never both text and close.
	`KVL_ASSERT(a_sub_has_entry, sub_q |-> !q_status.empty, "second result without an entry")
	`KVL_ASSERT(a_text_or_close, (out_valid_q && out_res_q.text_valid) |-> !out_res_q.token_done, "text and close in one result")

endmodule
`default_nettype wire

// ===== hdl/keyed_value_lexer.sv =====
// Top level of the keyed-value lexer: front end, result queue and back end.
//
// Usage: one character (in_byte) or an end mark (end_of_input) enters per transaction
// on the input channel; in_stall holds the source off while the internal queue is full.
// Each character gives zero, one or two result transactions on the output channel:
// token text bytes, closing results with token_kind and int_value, and an end-of-file
// result after an end mark. The last flag marks the final result of one input.
// Each result passes through a queue entry and then the output register, and a second
// result follows the first. Throughput is one character per cycle while in_stall is low;
// a character giving two results holds the single output register for both in turn,
// and the four-entry queue absorbs these bursts until in_stall rises.
// When out_stall is high the output register holds its result and the queue fills;
// characters that give no result never take a queue entry.
// cfg_data writes the longest identifier length; cfg_ready is always high, and the
// register should be written only while the block is idle.
// Reset (arst_n low) clears the lexer to between tokens, empties the queue and the
// output register, and sets the identifier limit to 1023.
`default_nettype none
module keyed_value_lexer #(
	parameter int ID_LEN_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   end_of_input,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        text_valid,
	output logic [7:0]                  text_byte,
	output logic                        token_done,
	output logic [2:0]                  token_kind,
	output logic signed [31:0]          int_value,
	output logic                        last,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [ID_LEN_BITS-1:0] cfg_data
);
	import kvl_pkg::*;

	logic      push, pop;
	entry_t    push_data, head;
	q_status_t q_status;
	result_t   out_res;

	// Character classification and lexer state.
	kvl_front #(
		.ID_LEN_BITS(ID_LEN_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_input(end_of_input),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.q_status    (q_status),
		.push        (push),
		.push_data   (push_data)
	);

	// Result entries waiting for the output side.
	kvl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// Result serialization and output register.
	kvl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res),
		.out_last (last)
	);

	// Result fields onto their ports.
	assign text_valid = out_res.text_valid;
	assign text_byte  = out_res.text_byte;
	assign token_done = out_res.token_done;
	assign token_kind = out_res.token_kind;
	assign int_value  = out_res.int_value;

endmodule
`default_nettype wire
